// ----- rtl/defp_pkg.sv -----
// Package for the display event frame parser.
// Holds the frame phase type, the event word type and fixed codes.
// No dependencies.
package defp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ID_W = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] TOUCH_START_RESET = 8'd101;
    localparam logic [BYTE_W-1:0] UPDATE_START_RESET = 8'd241;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOUCH_START = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_START = 1'b1;

    localparam logic EVENT_TOUCH = 1'b0;
    localparam logic EVENT_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_B1   = 4'd1,
        PH_B2   = 4'd2,
        PH_B3   = 4'd3,
        PH_B4   = 4'd4,
        PH_B5   = 4'd5,
        PH_B6   = 4'd6,
        PH_B7   = 4'd7,
        PH_B8   = 4'd8,
        PH_B9   = 4'd9,
        PH_B10  = 4'd10
    } t_phase;

    typedef struct packed {
        logic              event_kind;
        logic [ID_W-1:0]   component_id;
        logic [BYTE_W-1:0] action_code;
        logic [BYTE_W-1:0] arm_number;
        logic [BYTE_W-1:0] param_number;
        logic [WORD_W-1:0] param_word;
    } t_event;

endpackage

// ----- rtl/defp_in_stage.sv -----
// Input register for received bytes.
// Holds one word until the parser takes it. Uses defp_pkg.
module defp_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [defp_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_take,
    output logic                         o_valid,
    output logic [defp_pkg::BYTE_W-1:0]  o_data_byte
);

    logic                        r_valid;
    logic [defp_pkg::BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

// ----- rtl/defp_parser.sv -----
// Frame state machine and field capture for touch and update frames.
// Decodes one byte per take and flags a finished event. Uses defp_pkg.
module defp_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [defp_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [defp_pkg::BYTE_W-1:0]  i_touch_start,
    input  logic [defp_pkg::BYTE_W-1:0]  i_update_start,
    output logic                         o_emit,
    output defp_pkg::t_event             o_event
);

    defp_pkg::t_phase            r_phase, n_phase;
    logic                        r_upd, n_upd;
    logic [defp_pkg::BYTE_W-1:0] r_id_high, n_id_high;
    logic [defp_pkg::BYTE_W-1:0] r_id_low, n_id_low;
    logic [defp_pkg::BYTE_W-1:0] r_action, n_action;
    logic [defp_pkg::BYTE_W-1:0] r_arm, n_arm;
    logic [defp_pkg::BYTE_W-1:0] r_param, n_param;
    logic [defp_pkg::WORD_W-1:0] r_value, n_value;

    always_comb begin
        n_phase   = r_phase;
        n_upd     = r_upd;
        n_id_high = r_id_high;
        n_id_low  = r_id_low;
        n_action  = r_action;
        n_arm     = r_arm;
        n_param   = r_param;
        n_value   = r_value;
        if (i_take) begin
            unique case (r_phase)
                defp_pkg::PH_IDLE: begin
                    if (i_data_byte == i_touch_start) begin
                        n_upd   = 1'b0;
                        n_phase = defp_pkg::PH_B1;
                    end else if (i_data_byte == i_update_start) begin
                        n_upd   = 1'b1;
                        n_phase = defp_pkg::PH_B1;
                    end
                end
                defp_pkg::PH_B1: begin
                    if (r_upd) n_arm = i_data_byte;
                    else n_id_high = i_data_byte;
                    n_phase = defp_pkg::PH_B2;
                end
                defp_pkg::PH_B2: begin
                    if (!r_upd) n_id_low = i_data_byte;
                    n_phase = defp_pkg::PH_B3;
                end
                defp_pkg::PH_B3: begin
                    if (!r_upd) n_action = i_data_byte;
                    n_phase = defp_pkg::PH_B4;
                end
                defp_pkg::PH_B4: begin
                    n_phase = r_upd ? defp_pkg::PH_B5 : defp_pkg::PH_IDLE;
                end
                defp_pkg::PH_B5: begin
                    n_param = i_data_byte;
                    n_phase = r_upd ? defp_pkg::PH_B6 : defp_pkg::PH_IDLE;
                end
                defp_pkg::PH_B6: begin
                    n_value = {24'd0, i_data_byte};
                    n_phase = r_upd ? defp_pkg::PH_B7 : defp_pkg::PH_IDLE;
                end
                defp_pkg::PH_B7: begin
                    n_value[15:8] = i_data_byte;
                    n_phase = r_upd ? defp_pkg::PH_B8 : defp_pkg::PH_IDLE;
                end
                defp_pkg::PH_B8: begin
                    n_value[23:16] = i_data_byte;
                    n_phase = r_upd ? defp_pkg::PH_B9 : defp_pkg::PH_IDLE;
                end
                defp_pkg::PH_B9: begin
                    n_value[31:24] = i_data_byte;
                    n_phase = r_upd ? defp_pkg::PH_B10 : defp_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = defp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_emit = 1'b0;
        o_event = '0;
        if (r_upd) begin
            o_event.event_kind   = defp_pkg::EVENT_UPDATE;
            o_event.arm_number   = r_arm;
            o_event.param_number = r_param;
            o_event.param_word   = r_value;
            o_emit = i_take && (r_phase == defp_pkg::PH_B10)
                     && (i_data_byte == defp_pkg::TRAILER_BYTE);
        end else begin
            o_event.event_kind   = defp_pkg::EVENT_TOUCH;
            o_event.component_id = {r_id_high, r_id_low};
            o_event.action_code  = r_action;
            o_emit = i_take && (r_phase == defp_pkg::PH_B4)
                     && (i_data_byte == defp_pkg::TRAILER_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= defp_pkg::PH_IDLE;
            r_upd   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_upd   <= n_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id_high <= n_id_high;
        r_id_low  <= n_id_low;
        r_action  <= n_action;
        r_arm     <= n_arm;
        r_param   <= n_param;
        r_value   <= n_value;
    end

endmodule

// ----- rtl/defp_out_stage.sv -----
// Result register for decoded events.
// Holds one event word while the receiver stalls. Uses defp_pkg.
module defp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  defp_pkg::t_event  i_event,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output defp_pkg::t_event  o_event
);

    logic             r_valid;
    defp_pkg::t_event r_event;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= i_event;
        end
    end

endmodule

// ----- rtl/display_event_frame_parser_unit.sv -----
// Display event frame parser, top level.
// Instantiates defp_in_stage, defp_parser and defp_out_stage; uses defp_pkg.
//
// Input channel: i_valid / o_ready with i_data_byte, one received serial byte
// per word. Output channel: o_valid / i_ready with the event fields; one word
// leaves for each touch or update frame closed by a 0xFF trailer byte.
// Frames with a bad trailer, and bytes outside a frame, give no word.
// Configuration: i_cfg_we writes i_cfg_data to the start code selected by
// i_cfg_index (0 touch, 1 update); write only while no word is in flight.
// Path: an accepted trailer byte waits in the input register; when the parser
// takes it, the event word is loaded into the result register.
// Throughput: one byte per cycle while the result register has space; the
// frame state update is the single step between the two registers.
// Reset: synchronous, active low; empties both registers, returns to idle
// and loads the start codes 101 and 241.
// Stall: while an event word is held and i_ready is low, the word holds and
// the parser takes no further byte; one byte waits in the input register,
// and o_ready drops once that register is full.
module display_event_frame_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [defp_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_event_kind,
    output logic [defp_pkg::ID_W-1:0]       o_component_id,
    output logic [defp_pkg::BYTE_W-1:0]     o_action_code,
    output logic [defp_pkg::BYTE_W-1:0]     o_arm_number,
    output logic [defp_pkg::BYTE_W-1:0]     o_param_number,
    output logic [defp_pkg::WORD_W-1:0]     o_param_word,
    input  logic                            i_cfg_we,
    input  logic [defp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [defp_pkg::BYTE_W-1:0]     i_cfg_data
);

    logic [defp_pkg::BYTE_W-1:0] r_touch_start;
    logic [defp_pkg::BYTE_W-1:0] r_update_start;
    logic                        in_valid;
    logic [defp_pkg::BYTE_W-1:0] in_byte;
    logic                        out_space;
    logic                        take;
    logic                        emit;
    defp_pkg::t_event            new_event;
    defp_pkg::t_event            out_event;

    assign take = in_valid && out_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_start  <= defp_pkg::TOUCH_START_RESET;
            r_update_start <= defp_pkg::UPDATE_START_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                defp_pkg::CFG_TOUCH_START:  r_touch_start  <= i_cfg_data;
                defp_pkg::CFG_UPDATE_START: r_update_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    defp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_take      (take),
        .o_valid     (in_valid),
        .o_data_byte (in_byte)
    );

    defp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_data_byte    (in_byte),
        .i_touch_start  (r_touch_start),
        .i_update_start (r_update_start),
        .o_emit         (emit),
        .o_event        (new_event)
    );

    defp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_event (new_event),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_event (out_event)
    );

    assign o_event_kind   = out_event.event_kind;
    assign o_component_id = out_event.component_id;
    assign o_action_code  = out_event.action_code;
    assign o_arm_number   = out_event.arm_number;
    assign o_param_number = out_event.param_number;
    assign o_param_word   = out_event.param_word;

endmodule
